FILE: rtl/mrwt_pkg.sv
// ============================================================================
// Miller-Rabin witness test package
// Shared widths, sequencer states and the request and response bundles of
// the modular multiplier.
// ============================================================================
package mrwt_pkg;

   // Width of candidate and witness as used by the arithmetic.
   localparam int OPERAND_WIDTH = 32;
   // Fixed widths of the input fields on the ports.
   localparam int CANDIDATE_WIDTH = 32;
   localparam int WITNESS_WIDTH   = 32;

   // Step counter of the multiplier: counts OPERAND_WIDTH down to zero.
   localparam int MM_CNT_WIDTH = $clog2(OPERAND_WIDTH + 1);
   // Count of trailing zeros of n-1, at most OPERAND_WIDTH-1.
   localparam int TWOS_WIDTH = $clog2(OPERAND_WIDTH);

   // Sequencer states of the top level.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECOMP,
      ST_RED_GO,
      ST_RED_WAIT,
      ST_POW_CHECK,
      ST_ACC_GO,
      ST_ACC_WAIT,
      ST_BSQ_GO,
      ST_BSQ_WAIT,
      ST_TEST,
      ST_TSQ_GO,
      ST_TSQ_WAIT,
      ST_FINISH
   } state_type;

   // Request to the modular multiplier: x must be below the modulus.
   typedef struct packed {
      logic                     start;
      logic [OPERAND_WIDTH-1:0] x;
      logic [OPERAND_WIDTH-1:0] y;
   } mm_req_type;

   // Status and result of the modular multiplier.
   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic [OPERAND_WIDTH-1:0] result;
   } mm_rsp_type;

endpackage

FILE: rtl/mrwt_modmul.sv
// ============================================================================
// Modular multiplier
// Interleaved shift-add-reduce multiplier: computes x * y mod n one bit of y
// per cycle, most significant bit first, keeping the partial result below n.
// ============================================================================
module mrwt_modmul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mrwt_pkg::mm_req_type                  mm_req,
   input  logic [mrwt_pkg::OPERAND_WIDTH-1:0]    modulus,
   output mrwt_pkg::mm_rsp_type                  mm_rsp
);

   localparam int OW = mrwt_pkg::OPERAND_WIDTH;
   localparam int CW = mrwt_pkg::MM_CNT_WIDTH;

   logic [OW-1:0] r_ff, r_in;
   logic [OW-1:0] x_ff, x_in;
   logic [OW-1:0] y_ff, y_in;
   logic [OW-1:0] modulus_ff, modulus_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [OW-1:0] addend;
   logic [OW+1:0] sum;
   logic [OW+2:0] diff_one;
   logic [OW+2:0] diff_two;
   logic [OW-1:0] step;

   // One step: r = 2r + bit*x, then bring it back below n. The sum stays
   // below 3n, so subtracting n or 2n is always enough.
   always_comb begin
      addend   = y_ff[OW-1] ? x_ff : '0;
      sum      = {1'b0, r_ff, 1'b0} + {2'b00, addend};
      diff_one = {1'b0, sum} - {3'b000, modulus_ff};
      diff_two = {1'b0, sum} - {2'b00, modulus_ff, 1'b0};
      if (!diff_two[OW+2]) begin
         step = diff_two[OW-1:0];
      end else if (!diff_one[OW+2]) begin
         step = diff_one[OW-1:0];
      end else begin
         step = sum[OW-1:0];
      end
   end

   // Next-value logic of the step counter and operand registers.
   always_comb begin
      r_in       = r_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      modulus_in = modulus_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (mm_req.start) begin
         r_in       = '0;
         x_in       = mm_req.x;
         y_in       = mm_req.y;
         modulus_in = modulus;
         cnt_in     = CW'(OW);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         r_in   = step;
         y_in   = {y_ff[OW-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand registers.
   always_ff @(posedge clock) begin
      r_ff       <= r_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      modulus_ff <= modulus_in;
   end

   assign mm_rsp.busy   = busy_ff;
   assign mm_rsp.done   = done_ff;
   assign mm_rsp.result = r_ff;

`ifndef ASSERT_OFF
   // A finished product is fully reduced.
   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (r_ff < modulus_ff))
      else $error("modmul result not below modulus");

   // A started multiplication is under way in the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      mm_req.start |=> busy_ff)
      else $error("modmul did not start");

   // While busy, steps remain to be done.
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("modmul busy with no steps left");
`endif

endmodule

FILE: rtl/miller_rabin_witness_test_unit.sv
// ============================================================================
// Miller-Rabin witness test unit
// Takes a candidate n and a witness a in one beat and returns one verdict:
// probable_prime is 1 when the witness does not prove n composite, and
// invalid_input is 1 (verdict 0) for n below 3. The unit works on one beat
// at a time and stalls its input meanwhile. Its time is set by the shared
// bit-serial modular multiplier and the products that it computes: one
// reduction of a, one squaring and, for a set bit, one multiplication per
// bit of the odd part m of n-1, and up to k-1 squarings of t. On top come
// the exponent check per bit of m, the stripping of each trailing zero of
// n-1 and the sequencing. An early verdict ends the squarings of t, and an
// invalid candidate goes straight from its beat to its verdict.
// ============================================================================
module miller_rabin_witness_test_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mrwt_pkg::CANDIDATE_WIDTH-1:0]  req_candidate,
   input  logic [mrwt_pkg::WITNESS_WIDTH-1:0]    req_witness,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_probable_prime,
   output logic                                  rsp_invalid_input
);

   localparam int OW = mrwt_pkg::OPERAND_WIDTH;
   localparam int TW = mrwt_pkg::TWOS_WIDTH;

   mrwt_pkg::state_type state_ff, state_in;

   logic [OW-1:0] n_ff, n_in;
   logic [OW-1:0] a_ff, a_in;
   logic [OW-1:0] odd_ff, odd_in;
   logic [TW-1:0] twos_ff, twos_in;
   logic [TW-1:0] sq_left_ff, sq_left_in;
   logic [OW-1:0] acc_ff, acc_in;
   logic [OW-1:0] base_ff, base_in;
   logic          verdict_ff, verdict_in;
   logic          invalid_ff, invalid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_prime_ff, rsp_prime_in;
   logic          rsp_invalid_ff, rsp_invalid_in;

   logic [OW-1:0]        req_n;
   logic [OW-1:0]        req_a;
   logic [OW-1:0]        n_minus_one;
   logic                 req_accept;
   logic                 rsp_free;
   mrwt_pkg::mm_req_type mm_req;
   mrwt_pkg::mm_rsp_type mm_rsp;

   assign req_n       = req_candidate[OW-1:0];
   assign req_a       = req_witness[OW-1:0];
   assign n_minus_one = n_ff - OW'(1);
   assign req_stall   = (state_ff != mrwt_pkg::ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   // Shared modular multiplier.
   mrwt_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .mm_req  (mm_req),
      .modulus (n_ff),
      .mm_rsp  (mm_rsp)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mrwt_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_n < OW'(3)) ? mrwt_pkg::ST_FINISH : mrwt_pkg::ST_DECOMP;
            end
         end
         mrwt_pkg::ST_DECOMP: begin
            if (odd_ff[0]) begin
               state_in = mrwt_pkg::ST_RED_GO;
            end
         end
         mrwt_pkg::ST_RED_GO:  state_in = mrwt_pkg::ST_RED_WAIT;
         mrwt_pkg::ST_RED_WAIT: begin
            if (mm_rsp.done) begin
               state_in = mrwt_pkg::ST_POW_CHECK;
            end
         end
         mrwt_pkg::ST_POW_CHECK: begin
            if (odd_ff == '0) begin
               state_in = mrwt_pkg::ST_TEST;
            end else if (odd_ff[0]) begin
               state_in = mrwt_pkg::ST_ACC_GO;
            end else begin
               state_in = mrwt_pkg::ST_BSQ_GO;
            end
         end
         mrwt_pkg::ST_ACC_GO:  state_in = mrwt_pkg::ST_ACC_WAIT;
         mrwt_pkg::ST_ACC_WAIT: begin
            if (mm_rsp.done) begin
               state_in = mrwt_pkg::ST_BSQ_GO;
            end
         end
         mrwt_pkg::ST_BSQ_GO:  state_in = mrwt_pkg::ST_BSQ_WAIT;
         mrwt_pkg::ST_BSQ_WAIT: begin
            if (mm_rsp.done) begin
               state_in = mrwt_pkg::ST_POW_CHECK;
            end
         end
         mrwt_pkg::ST_TEST: begin
            if (acc_ff == OW'(1) || acc_ff == n_minus_one || twos_ff <= TW'(1)) begin
               state_in = mrwt_pkg::ST_FINISH;
            end else begin
               state_in = mrwt_pkg::ST_TSQ_GO;
            end
         end
         mrwt_pkg::ST_TSQ_GO:  state_in = mrwt_pkg::ST_TSQ_WAIT;
         mrwt_pkg::ST_TSQ_WAIT: begin
            if (mm_rsp.done) begin
               if (mm_rsp.result == OW'(1) || mm_rsp.result == n_minus_one ||
                   sq_left_ff == TW'(1)) begin
                  state_in = mrwt_pkg::ST_FINISH;
               end else begin
                  state_in = mrwt_pkg::ST_TSQ_GO;
               end
            end
         end
         mrwt_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = mrwt_pkg::ST_IDLE;
            end
         end
         default: state_in = mrwt_pkg::ST_IDLE;
      endcase
   end

   // Datapath and multiplier requests for each state.
   always_comb begin
      n_in           = n_ff;
      a_in           = a_ff;
      odd_in         = odd_ff;
      twos_in        = twos_ff;
      sq_left_in     = sq_left_ff;
      acc_in         = acc_ff;
      base_in        = base_ff;
      verdict_in     = verdict_ff;
      invalid_in     = invalid_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_prime_in   = rsp_prime_ff;
      rsp_invalid_in = rsp_invalid_ff;
      mm_req.start   = 1'b0;
      mm_req.x       = acc_ff;
      mm_req.y       = base_ff;
      case (state_ff)
         mrwt_pkg::ST_IDLE: begin
            if (req_accept) begin
               n_in       = req_n;
               a_in       = req_a;
               odd_in     = req_n - OW'(1);
               twos_in    = '0;
               verdict_in = 1'b0;
               invalid_in = (req_n < OW'(3));
            end
         end
         // Strip trailing zeros of n-1, one per cycle.
         mrwt_pkg::ST_DECOMP: begin
            if (!odd_ff[0]) begin
               odd_in  = {1'b0, odd_ff[OW-1:1]};
               twos_in = twos_ff + TW'(1);
            end
         end
         // Reduce the witness as 1 * a mod n.
         mrwt_pkg::ST_RED_GO: begin
            mm_req.start = 1'b1;
            mm_req.x     = OW'(1);
            mm_req.y     = a_ff;
         end
         mrwt_pkg::ST_RED_WAIT: begin
            if (mm_rsp.done) begin
               base_in = mm_rsp.result;
               acc_in  = OW'(1);
            end
         end
         mrwt_pkg::ST_ACC_GO: begin
            mm_req.start = 1'b1;
         end
         mrwt_pkg::ST_ACC_WAIT: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.result;
            end
         end
         mrwt_pkg::ST_BSQ_GO: begin
            mm_req.start = 1'b1;
            mm_req.x     = base_ff;
         end
         mrwt_pkg::ST_BSQ_WAIT: begin
            if (mm_rsp.done) begin
               base_in = mm_rsp.result;
               odd_in  = {1'b0, odd_ff[OW-1:1]};
            end
         end
         // First check of t = a^m mod n.
         mrwt_pkg::ST_TEST: begin
            verdict_in = (acc_ff == OW'(1) || acc_ff == n_minus_one);
            sq_left_in = twos_ff - TW'(1);
         end
         mrwt_pkg::ST_TSQ_GO: begin
            mm_req.start = 1'b1;
            mm_req.y     = acc_ff;
         end
         // Repeated squaring: n-1 proves nothing, 1 proves composite.
         mrwt_pkg::ST_TSQ_WAIT: begin
            if (mm_rsp.done) begin
               acc_in     = mm_rsp.result;
               verdict_in = (mm_rsp.result == n_minus_one);
               sq_left_in = sq_left_ff - TW'(1);
            end
         end
         mrwt_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_prime_in   = verdict_ff && !invalid_ff;
               rsp_invalid_in = invalid_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrwt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      n_ff           <= n_in;
      a_ff           <= a_in;
      odd_ff         <= odd_in;
      twos_ff        <= twos_in;
      sq_left_ff     <= sq_left_in;
      acc_ff         <= acc_in;
      base_ff        <= base_in;
      verdict_ff     <= verdict_in;
      invalid_ff     <= invalid_in;
      rsp_prime_ff   <= rsp_prime_in;
      rsp_invalid_ff <= rsp_invalid_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_probable_prime = rsp_prime_ff;
   assign rsp_invalid_input  = rsp_invalid_ff;

`ifndef ASSERT_OFF
   // The multiplier is only started when it is free.
   a_mm_start_free: assert property (@(posedge clock) disable iff (reset)
      mm_req.start |-> !mm_rsp.busy)
      else $error("multiplier started while busy");

   // A finished product arrives only while the sequencer waits for one.
   a_mm_done_waiting: assert property (@(posedge clock) disable iff (reset)
      mm_rsp.done |-> (state_ff == mrwt_pkg::ST_RED_WAIT ||
                       state_ff == mrwt_pkg::ST_ACC_WAIT ||
                       state_ff == mrwt_pkg::ST_BSQ_WAIT ||
                       state_ff == mrwt_pkg::ST_TSQ_WAIT))
      else $error("product arrived outside a wait state");

   // An invalid candidate never carries a prime verdict.
   a_invalid_not_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_invalid_ff && rsp_prime_ff))
      else $error("invalid candidate reported prime");
`endif

endmodule
